// File: rtl/rnfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rnfe_pkg
// Shared types, field positions, command codes and register indexes of the
// ring node frame engine.
// -----------------------------------------------------------------------------
package rnfe_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // input item modes
   localparam logic [1:0] MODE_RX    = 2'd0;
   localparam logic [1:0] MODE_PRESS = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // byte positions within a frame
   localparam logic [POS_W-1:0] POS_PAD0  = 4'd0;
   localparam logic [POS_W-1:0] POS_DEST  = 4'd1;
   localparam logic [POS_W-1:0] POS_SRC   = 4'd2;
   localparam logic [POS_W-1:0] POS_PROTO = 4'd3;
   localparam logic [POS_W-1:0] POS_HOP   = 4'd4;
   localparam logic [POS_W-1:0] POS_CMD   = 4'd5;
   localparam logic [POS_W-1:0] POS_DATA0 = 4'd6;
   localparam logic [POS_W-1:0] POS_DATA3 = 4'd9;
   localparam logic [POS_W-1:0] POS_DATA6 = 4'd12;
   localparam logic [POS_W-1:0] POS_DATA7 = 4'd13;
   localparam logic [POS_W-1:0] POS_CHECK = 4'd14;
   localparam logic [POS_W-1:0] POS_PAD1  = 4'd15;

   localparam logic [7:0] PROTO_ID    = 8'd4;
   localparam logic [7:0] MASTER_ADDR = 8'h00;

   localparam logic [7:0] CMD_LED    = 8'd100;
   localparam logic [7:0] CMD_PRESS  = 8'd101;
   localparam logic [7:0] CMD_UID_LO = 8'd102;
   localparam logic [7:0] CMD_UID_HI = 8'd103;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_NODE_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_UID_LOW   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UID_MID   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_UID_HIGH  = 3'd4;

   localparam logic [7:0]  NODE_ADDR_RESET = 8'd111;
   localparam logic [31:0] DEBOUNCE_RESET  = 32'd1600000;

   typedef struct packed {
      logic [7:0]  node_address;
      logic [31:0] debounce_ticks;
      logic [31:0] unique_id_low;
      logic [31:0] unique_id_mid;
      logic [31:0] unique_id_high;
   } cfg_type;

   typedef struct packed {
      logic press;
      logic tick;
      logic clear;
   } dbn_ctl_type;

endpackage

`default_nettype wire

// File: rtl/rnfe_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rnfe channels
// Valid/ready channel interfaces: received items, outgoing frame beats and
// register writes.
// -----------------------------------------------------------------------------
interface rnfe_req_if import rnfe_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface rnfe_rsp_if import rnfe_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;
   logic       is_reply;
   logic       led_on;

   modport source (output valid, output tx_byte, output last_byte, output is_reply,
                   output led_on, input ready);
   modport sink   (input valid, input tx_byte, input last_byte, input is_reply,
                   input led_on, output ready);
endinterface

interface rnfe_csr_if import rnfe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/rnfe_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rnfe_csr
// Configuration registers: node address, debounce length, unique-id words.
// -----------------------------------------------------------------------------
module rnfe_csr import rnfe_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   rnfe_csr_if.sink    csr_bus,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_address   <= NODE_ADDR_RESET;
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.unique_id_low  <= '0;
         cfg_ff.unique_id_mid  <= '0;
         cfg_ff.unique_id_high <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            CSR_NODE_ADDR: cfg_ff.node_address   <= csr_bus.wdata[7:0];
            CSR_DEBOUNCE:  cfg_ff.debounce_ticks <= csr_bus.wdata;
            CSR_UID_LOW:   cfg_ff.unique_id_low  <= csr_bus.wdata;
            CSR_UID_MID:   cfg_ff.unique_id_mid  <= csr_bus.wdata;
            CSR_UID_HIGH:  cfg_ff.unique_id_high <= csr_bus.wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/rnfe_debounce.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rnfe_debounce
// Button press counter with a tick-timed lockout after each accepted press.
// -----------------------------------------------------------------------------
module rnfe_debounce import rnfe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dbn_ctl_type ctl,
   input  wire logic [31:0] debounce_ticks,
   output logic [7:0]       press_count
);

   logic [7:0]  count_ff;
   logic        active_ff;
   logic [31:0] ticks_ff;
   logic [31:0] ticks_in;

   assign press_count = count_ff;
   assign ticks_in    = ticks_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b0;
         ticks_ff  <= '0;
      end else begin
         if (ctl.clear) begin
            count_ff <= '0;
         end else if (ctl.press && !active_ff) begin
            count_ff  <= count_ff + 8'd1;
            active_ff <= 1'b1;
            ticks_ff  <= '0;
         end
         if (ctl.tick && active_ff) begin
            // a zero setting ends the lockout on the first tick, same as one
            if (ticks_in >= debounce_ticks) begin
               active_ff <= 1'b0;
               ticks_ff  <= '0;
            end else begin
               ticks_ff <= ticks_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/rnfe_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rnfe_seq
// Frame store and sequencer: collects bytes, verifies the checksum with a
// shared 8-bit adder, decodes the header and streams the outgoing frame while
// the same adder rebuilds its checksum.
// -----------------------------------------------------------------------------
module rnfe_seq import rnfe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   rnfe_req_if.sink     req_bus,
   rnfe_rsp_if.source   rsp_bus,
   input  wire cfg_type cfg,
   input  wire logic [7:0] press_count,
   output dbn_ctl_type  dbn_ctl
);

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DECIDE, ST_EMIT} state_type;

   state_type        state_ff;
   logic [7:0]       store_ff [FRAME_BYTES];
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] k_ff;
   logic [7:0]       sum_ff;
   logic [7:0]       dest_ff;
   logic [7:0]       src_ff;
   logic [7:0]       proto_ff;
   logic [7:0]       cmd_ff;
   logic [7:0]       data7_ff;
   logic             ok_ff;
   logic             reply_ff;
   logic [7:0]       snap_ff;
   logic             led_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;
   logic             out_reply_ff;
   logic             out_led_ff;

   logic       accept;
   logic [7:0] rd_byte;
   logic [7:0] emit_byte;
   logic [7:0] add_op;
   logic [7:0] add_sum;
   logic [1:0] uid_idx;
   logic       hdr_ok;
   logic       for_me;
   logic       load;
   logic       in_body;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.tx_byte   = out_byte_ff;
   assign rsp_bus.last_byte = out_last_ff;
   assign rsp_bus.is_reply  = out_reply_ff;
   assign rsp_bus.led_on    = out_led_ff;

   assign rd_byte = store_ff[k_ff];

   // shared adder: checksum verify on the way in, rebuild on the way out
   assign add_op  = (state_ff == ST_CHECK) ? rd_byte : emit_byte;
   assign add_sum = sum_ff + add_op;

   assign hdr_ok  = ok_ff && (proto_ff == PROTO_ID) && (src_ff == MASTER_ADDR) &&
                    (dest_ff != MASTER_ADDR);
   assign for_me  = hdr_ok && (dest_ff == cfg.node_address);
   assign load    = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_bus.ready);
   assign in_body = (k_ff >= POS_DEST) && (k_ff <= POS_DATA7);

   assign dbn_ctl.press = accept && (req_bus.mode == MODE_PRESS);
   assign dbn_ctl.tick  = accept && (req_bus.mode == MODE_TICK);
   assign dbn_ctl.clear = (state_ff == ST_DECIDE) && for_me && (cmd_ff == CMD_PRESS);

   always_comb begin
      uid_idx   = k_ff[1:0] - 2'd2;
      emit_byte = rd_byte;
      priority if (k_ff == POS_PAD0 || k_ff == POS_PAD1) begin
         emit_byte = 8'h00;
      end else if (k_ff == POS_CHECK) begin
         emit_byte = ~sum_ff;
      end else if (!reply_ff) begin
         if (k_ff == POS_HOP) begin
            emit_byte = rd_byte + 8'd1;
         end
      end else if (k_ff == POS_DEST) begin
         emit_byte = MASTER_ADDR;
      end else if (k_ff == POS_SRC) begin
         emit_byte = cfg.node_address;
      end else if (k_ff == POS_PROTO) begin
         emit_byte = PROTO_ID;
      end else if (k_ff == POS_HOP) begin
         emit_byte = 8'h00;
      end else if (k_ff >= POS_DATA0) begin
         priority if (cmd_ff == CMD_PRESS) begin
            if (k_ff == POS_DATA7) begin
               emit_byte = snap_ff;
            end
         end else if (cmd_ff == CMD_UID_LO) begin
            if (k_ff <= POS_DATA3) begin
               emit_byte = cfg.unique_id_low[8*uid_idx +: 8];
            end else if (k_ff <= POS_DATA6) begin
               emit_byte = cfg.unique_id_mid[8*uid_idx +: 8];
            end
         end else if (cmd_ff == CMD_UID_HI) begin
            if (k_ff <= POS_DATA3) begin
               emit_byte = cfg.unique_id_high[8*uid_idx +: 8];
            end
         end else begin
            emit_byte = rd_byte;
         end
      end else begin
         emit_byte = rd_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_bus.mode == MODE_RX) begin
         store_ff[pos_ff] <= req_bus.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         led_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready && !load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_bus.mode == MODE_RX) begin
                  pos_ff <= pos_ff + 1'b1;
                  if (pos_ff == POS_PAD1) begin
                     state_ff <= ST_CHECK;
                     k_ff     <= POS_DEST;
                     sum_ff   <= '0;
                  end
               end
            end
            ST_CHECK: begin
               if (k_ff == POS_CHECK) begin
                  ok_ff    <= (rd_byte == ~sum_ff);
                  state_ff <= ST_DECIDE;
               end else begin
                  sum_ff <= add_sum;
                  k_ff   <= k_ff + 1'b1;
               end
               if (k_ff == POS_DEST)  dest_ff  <= rd_byte;
               if (k_ff == POS_SRC)   src_ff   <= rd_byte;
               if (k_ff == POS_PROTO) proto_ff <= rd_byte;
               if (k_ff == POS_CMD)   cmd_ff   <= rd_byte;
               if (k_ff == POS_DATA7) data7_ff <= rd_byte;
            end
            ST_DECIDE: begin
               k_ff     <= POS_PAD0;
               sum_ff   <= '0;
               snap_ff  <= press_count;
               if (hdr_ok && !for_me) begin
                  reply_ff <= 1'b0;
                  state_ff <= ST_EMIT;
               end else if (for_me) begin
                  reply_ff <= 1'b1;
                  unique case (cmd_ff)
                     CMD_LED: begin
                        led_ff   <= (data7_ff != 8'h00);
                        state_ff <= ST_EMIT;
                     end
                     CMD_PRESS, CMD_UID_LO, CMD_UID_HI: begin
                        state_ff <= ST_EMIT;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (load) begin
                  out_valid_ff <= 1'b1;
                  out_byte_ff  <= emit_byte;
                  out_last_ff  <= (k_ff == POS_PAD1);
                  out_reply_ff <= reply_ff;
                  out_led_ff   <= led_ff;
                  if (in_body) begin
                     sum_ff <= add_sum;
                  end
                  k_ff <= k_ff + 1'b1;
                  if (k_ff == POS_PAD1) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // a frame is only checked once the byte position has wrapped
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (pos_ff == '0))
      else $error("frame check started with partial frame");

   // press count is cleared only by a valid read-count request for this node
   assert property (@(posedge clock) disable iff (reset)
      dbn_ctl.clear |-> (state_ff == ST_DECIDE && ok_ff && dest_ff == cfg.node_address))
      else $error("press count cleared outside a matching request");

   // output beats are only loaded while streaming a frame
   assert property (@(posedge clock) disable iff (reset)
      ($rose(out_valid_ff)) |-> ($past(state_ff) == ST_EMIT))
      else $error("output beat loaded outside frame streaming");

   // the last beat of a frame carries the padding byte
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_byte_ff == 8'h00))
      else $error("last beat is not padding");
`endif

endmodule

`default_nettype wire

// File: rtl/ring_node_frame_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ring_node_frame_engine_unit
// Byte-serial ring node: frame collection, checksum, forwarding and replies.
// -----------------------------------------------------------------------------
// A received byte, a button press or a timer tick is taken whenever the engine
// is idle. When the sixteenth byte of a frame arrives the engine stops taking
// beats: its one 8-bit adder walks the frame store to verify the checksum, the
// decide state decodes the header, and a forwarded or reply frame then leaves as
// 16 beats, at most one per cycle, while the same adder builds the new
// checksum. Input resumes once the last beat is loaded into the output
// register, so any stall on the output side also holds off input, and a
// dropped frame returns to idle straight after the header is decoded.
module ring_node_frame_engine_unit import rnfe_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   rnfe_req_if.sink   req_bus,
   rnfe_rsp_if.source rsp_bus,
   rnfe_csr_if.sink   csr_bus
);

   cfg_type     cfg;
   dbn_ctl_type dbn_ctl;
   logic [7:0]  press_count;

   rnfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rnfe_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .ctl            (dbn_ctl),
      .debounce_ticks (cfg.debounce_ticks),
      .press_count    (press_count)
   );

   rnfe_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .cfg         (cfg),
      .press_count (press_count),
      .dbn_ctl     (dbn_ctl)
   );

endmodule

`default_nettype wire

// File: tb/ring_node_frame_engine_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ring_node_frame_engine_unit_tb
// Self-checking bench for the ring node frame engine. Streams of frames,
// button presses and timer ticks go in, a predictor tracks frame assembly,
// checksums, forwarding, replies and debounce, and every outgoing frame beat
// is compared against the predicted beat. Several register settings and
// idle patterns are exercised, along with one long output back-pressure stretch.
// -----------------------------------------------------------------------------
module ring_node_frame_engine_unit_tb;
   import rnfe_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [7:0] CMD_UNUSED  = 8'd99;
   localparam int         DRAIN_WAIT  = 40;
   localparam int         STALL_LEN   = 400;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_item_t;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       is_reply;
      logic       led_on;
   } tx_beat_t;

   logic clock;
   logic reset;

   rnfe_req_if req_bus ();
   rnfe_rsp_if rsp_bus ();
   rnfe_csr_if csr_bus ();

   ring_node_frame_engine_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // register copies
   logic [7:0]  cfg_node;
   logic [31:0] cfg_debounce;
   logic [31:0] cfg_uid_lo;
   logic [31:0] cfg_uid_mid;
   logic [31:0] cfg_uid_hi;

   // node state
   frame_t      rx_frame;
   logic [3:0]  rx_pos;
   logic [7:0]  presses;
   logic        locked;
   logic [31:0] lock_ticks;
   logic        led;

   tx_beat_t  tx_beats_due[$];
   req_item_t req_items_todo[$];

   // stimulus generator state
   logic [7:0] gen_node;
   logic [3:0] gen_pos;
   int         event_pct;
   int         send_idle_pct;
   int         rcv_idle_pct;
   logic       stall_req;
   bit         stall_taken;
   int         stall_left;
   int         fail_count;

   req_item_t req_now;
   req_item_t req_next;
   tx_beat_t  due;

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] frame_check(input frame_t f);
      logic [7:0] s;
      s = 8'd0;
      for (int k = 1; k <= 13; k++) s = s + f[k];
      return ~s;
   endfunction

   function automatic void queue_tx_frame(input frame_t f, input logic reply);
      tx_beat_t b;
      f[POS_PAD0]  = 8'd0;
      f[POS_CHECK] = frame_check(f);
      f[POS_PAD1]  = 8'd0;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         b.tx_byte   = f[k];
         b.last_byte = (k == FRAME_BYTES - 1);
         b.is_reply  = reply;
         b.led_on    = led;
         tx_beats_due.push_back(b);
      end
   endfunction

   function automatic void handle_rx_frame();
      frame_t f;
      f = rx_frame;
      if (f[POS_CHECK] != frame_check(f)) return;
      if (f[POS_PROTO] != PROTO_ID || f[POS_SRC] != MASTER_ADDR || f[POS_DEST] == MASTER_ADDR)
         return;
      if (f[POS_DEST] != cfg_node) begin
         f[POS_HOP] = f[POS_HOP] + 8'd1;
         queue_tx_frame(f, 1'b0);
         return;
      end
      case (f[POS_CMD])
         CMD_LED: begin
            led = (f[POS_DATA7] != 8'd0);
         end
         CMD_PRESS: begin
            f[POS_DATA7] = presses;
            presses = 8'd0;
         end
         CMD_UID_LO: begin
            f[POS_DATA3:POS_DATA0]        = cfg_uid_lo;
            f[POS_DATA6:POS_DATA3 + 4'd1] = cfg_uid_mid[23:0];
         end
         CMD_UID_HI: begin
            f[POS_DATA3:POS_DATA0] = cfg_uid_hi;
         end
         default: return;
      endcase
      f[POS_DEST]  = MASTER_ADDR;
      f[POS_SRC]   = cfg_node;
      f[POS_PROTO] = PROTO_ID;
      f[POS_HOP]   = 8'd0;
      queue_tx_frame(f, 1'b1);
   endfunction

   function automatic void node_step(input req_item_t it);
      case (it.mode)
         MODE_RX: begin
            rx_frame[rx_pos] = it.rx_byte;
            rx_pos = rx_pos + 4'd1;
            if (rx_pos == 4'd0) handle_rx_frame();
         end
         MODE_PRESS: begin
            if (!locked) begin
               presses    = presses + 8'd1;
               locked     = 1'b1;
               lock_ticks = 32'd0;
            end
         end
         MODE_TICK: begin
            if (locked) begin
               lock_ticks = lock_ticks + 32'd1;
               if (lock_ticks >= cfg_debounce) begin
                  locked     = 1'b0;
                  lock_ticks = 32'd0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void push_item(input logic [1:0] mode, input logic [7:0] b);
      req_item_t it;
      it.mode    = mode;
      it.rx_byte = b;
      req_items_todo.push_back(it);
      if (mode == MODE_RX) gen_pos = gen_pos + 4'd1;
   endfunction

   function automatic void add_button_events();
      push_item(MODE_PRESS, 8'($urandom));
      repeat ($urandom_range(4, 0)) push_item(MODE_TICK, 8'($urandom));
   endfunction

   function automatic void send_frame(input logic [7:0] dest, input logic [7:0] src,
                                      input logic [7:0] proto, input logic [7:0] hop,
                                      input logic [7:0] cmd, input logic [63:0] data,
                                      input logic bad_check);
      frame_t f;
      f[POS_PAD0]              = 8'($urandom);
      f[POS_DEST]              = dest;
      f[POS_SRC]               = src;
      f[POS_PROTO]             = proto;
      f[POS_HOP]               = hop;
      f[POS_CMD]               = cmd;
      f[POS_DATA7:POS_DATA0]   = data;
      f[POS_CHECK]             = frame_check(f) ^
                                 (bad_check ? (8'd1 << $urandom_range(7, 0)) : 8'd0);
      f[POS_PAD1]              = 8'($urandom);
      // junk bytes to close any partial frame left by noise
      while (gen_pos != 4'd0) push_item(MODE_RX, 8'($urandom));
      for (int k = 0; k < FRAME_BYTES; k++) begin
         if ($urandom_range(99, 0) < event_pct) add_button_events();
         push_item(MODE_RX, f[k]);
      end
   endfunction

   function automatic void add_random_traffic(input int n);
      int          goal;
      int          pick;
      logic [7:0]  dest;
      logic [7:0]  src;
      logic [7:0]  proto;
      logic [7:0]  cmd;
      logic [63:0] data;
      goal = req_items_todo.size() + n;
      while (req_items_todo.size() < goal) begin
         pick = $urandom_range(99, 0);
         data = {$urandom, $urandom};
         if ($urandom_range(1, 0)) data[63:56] = 8'd0;
         cmd = CMD_LED + 8'($urandom_range(3, 0));
         if ($urandom_range(9, 0) == 0) cmd = 8'($urandom);
         if (pick < 35) begin
            send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'($urandom), cmd, data, 1'b0);
         end else if (pick < 60) begin
            do dest = 8'($urandom_range(255, 1)); while (dest == gen_node);
            send_frame(dest, MASTER_ADDR, PROTO_ID, 8'($urandom), 8'($urandom), data, 1'b0);
         end else if (pick < 70) begin
            // header that must be dropped despite a good checksum
            dest  = $urandom_range(1, 0) ? gen_node : 8'($urandom);
            src   = MASTER_ADDR;
            proto = PROTO_ID;
            case ($urandom_range(2, 0))
               0: dest = MASTER_ADDR;
               1: src = 8'($urandom_range(255, 1));
               default: begin
                  proto = 8'($urandom);
                  if (proto == PROTO_ID) proto = ~proto;
               end
            endcase
            send_frame(dest, src, proto, 8'($urandom), cmd, data, 1'b0);
         end else if (pick < 80) begin
            send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'($urandom), cmd, data, 1'b1);
         end else if (pick < 88) begin
            repeat ($urandom_range(15, 1)) push_item(MODE_RX, 8'($urandom));
         end else if (pick < 97) begin
            add_button_events();
         end else begin
            push_item(MODE_UNUSED, 8'($urandom));
         end
      end
   endfunction

   // ---------------------------------------------------------------- registers

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.wdata <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_NODE_ADDR: cfg_node     = val[7:0];
         CSR_DEBOUNCE:  cfg_debounce = val;
         CSR_UID_LOW:   cfg_uid_lo   = val;
         CSR_UID_MID:   cfg_uid_mid  = val;
         CSR_UID_HIGH:  cfg_uid_hi   = val;
         default: ;
      endcase
   endtask

   task automatic set_phase(input logic [7:0] node, input logic [31:0] debounce,
                            input logic [31:0] lo, input logic [31:0] mid,
                            input logic [31:0] hi, input int snd_idle, input int rcv_idle);
      csr_write(CSR_NODE_ADDR, {24'd0, node});
      csr_write(CSR_DEBOUNCE, debounce);
      csr_write(CSR_UID_LOW, lo);
      csr_write(CSR_UID_MID, mid);
      csr_write(CSR_UID_HIGH, hi);
      gen_node      = node;
      send_idle_pct = snd_idle;
      rcv_idle_pct  = rcv_idle;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (req_items_todo.size() != 0 || req_bus.valid || tx_beats_due.size() != 0);
      // a dropped frame may still be in the checksum walk
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- clock

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            req_now.mode    = req_bus.mode;
            req_now.rx_byte = req_bus.rx_byte;
            node_step(req_now);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_items_todo.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_next = req_items_todo.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.mode    <= req_next.mode;
               req_bus.rx_byte <= req_next.rx_byte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (tx_beats_due.size() == 0) begin
               $error("unexpected beat: tx_byte %0d", rsp_bus.tx_byte);
               fail_count++;
            end else begin
               due = tx_beats_due.pop_front();
               if (rsp_bus.tx_byte !== due.tx_byte) begin
                  $error("tx_byte: expected %0d, actual %0d", due.tx_byte, rsp_bus.tx_byte);
                  fail_count++;
               end
               if (rsp_bus.last_byte !== due.last_byte) begin
                  $error("last_byte: expected %0d, actual %0d", due.last_byte,
                         rsp_bus.last_byte);
                  fail_count++;
               end
               if (rsp_bus.is_reply !== due.is_reply) begin
                  $error("is_reply: expected %0d, actual %0d", due.is_reply, rsp_bus.is_reply);
                  fail_count++;
               end
               if (rsp_bus.led_on !== due.led_on) begin
                  $error("led_on: expected %0d, actual %0d", due.led_on, rsp_bus.led_on);
                  fail_count++;
               end
            end
         end
         if (stall_req && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = STALL_LEN;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_RX;
      req_bus.rx_byte = 8'd0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.addr    = CSR_NODE_ADDR;
      csr_bus.wdata   = 32'd0;
      cfg_node        = NODE_ADDR_RESET;
      cfg_debounce    = DEBOUNCE_RESET;
      cfg_uid_lo      = 32'd0;
      cfg_uid_mid     = 32'd0;
      cfg_uid_hi      = 32'd0;
      rx_frame        = '0;
      rx_pos          = 4'd0;
      presses         = 8'd0;
      locked          = 1'b0;
      lock_ticks      = 32'd0;
      led             = 1'b0;
      gen_node        = NODE_ADDR_RESET;
      gen_pos         = 4'd0;
      event_pct       = 0;
      send_idle_pct   = 0;
      rcv_idle_pct    = 0;
      stall_req       = 1'b0;
      stall_taken     = 1'b0;
      stall_left      = 0;
      fail_count      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: zero debounce behaves as one tick
      set_phase(NODE_ADDR_RESET, 32'd0, 32'h89AB_CDEF, 32'h0123_4567, 32'hFEDC_BA98, 23, 52);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'd0, CMD_LED, {8'hFF, 56'd0}, 1'b0);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'hFF, CMD_UID_LO, 64'd0, 1'b0);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'd0, CMD_UID_HI, '1, 1'b0);
      push_item(MODE_PRESS, 8'h00);
      push_item(MODE_PRESS, 8'hFF);   // locked out
      push_item(MODE_TICK, 8'h00);
      push_item(MODE_TICK, 8'hFF);    // no lockout, ignored
      push_item(MODE_PRESS, 8'h5A);
      push_item(MODE_UNUSED, 8'hA5);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'd0, CMD_PRESS, {$urandom, $urandom}, 1'b0);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'd0, CMD_UNUSED, 64'd0, 1'b0);
      send_frame(8'd200, MASTER_ADDR, PROTO_ID, 8'hFF, CMD_LED, {$urandom, $urandom}, 1'b0);
      send_frame(MASTER_ADDR, MASTER_ADDR, PROTO_ID, 8'd0, CMD_LED, 64'd1, 1'b0);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'd0, CMD_LED, 64'd0, 1'b1);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID + 8'd1, 8'd0, CMD_LED, 64'd0, 1'b0);
      send_frame(gen_node, 8'd7, PROTO_ID, 8'd0, CMD_LED, 64'd0, 1'b0);
      send_frame(gen_node, MASTER_ADDR, PROTO_ID, 8'd0, CMD_LED, 64'd0, 1'b0);
      wait_drained();

      // sender idles less than receiver
      set_phase(8'd255, 32'd1, '1, '1, '1, 23, 52);
      event_pct = 10;
      add_random_traffic(12);
      wait_drained();

      set_phase(8'd1, $urandom_range(5, 2), $urandom, $urandom, $urandom, 52, 23);
      add_random_traffic(12);
      wait_drained();

      // no idling; long output hold-off fills the engine
      set_phase(8'($urandom_range(254, 2)), '1, 32'd0, 32'd0, 32'd0, 0, 0);
      send_frame(8'd1, MASTER_ADDR, PROTO_ID, 8'd0, CMD_LED, {$urandom, $urandom}, 1'b0);
      add_random_traffic(8);
      stall_req <= 1'b1;
      wait_drained();

      set_phase(8'd0, 32'd2, $urandom, $urandom, $urandom, 0, 0);
      add_random_traffic(8);
      wait_drained();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/rnfe_pkg.sv
rtl/rnfe_channels.sv
rtl/rnfe_csr.sv
rtl/rnfe_debounce.sv
rtl/rnfe_seq.sv
rtl/ring_node_frame_engine_unit.sv
tb/ring_node_frame_engine_unit_tb.sv
